@@ rtl/core/chacha_pkg.sv @@
// Shared types, constants and the quarter-round helper for the ChaCha20 stream core.
// Used by chacha_ctrl, chacha_dp and chacha20_stream_xor_core; depends on nothing.
package chacha_pkg;

    typedef logic [31:0] word_t;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] CFG_KEY_01    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_23    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY_45    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY_67    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_NONCE_01  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_NONCE_2   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_INIT_CTR  = 3'd6;

    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3332_206e;
    localparam word_t SIGMA_2 = 32'h7962_2d32;
    localparam word_t SIGMA_3 = 32'h6b20_6574;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } qr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // load the working state from key, nonce and counter
        logic new_msg;    // take the counter from the configured start value
        logic capture;    // hold the accepted word while the block is made
        logic step;       // one half quarter-round on all four lanes
        logic diag;       // diagonal round rather than column round
        logic second;     // second half of the quarter round (rotations 8 and 7)
        logic finish;     // add the input state back in to form the keystream
        logic emit;       // write a result word into the output register
        logic emit_hold;  // result comes from the held word, not the input port
    } cmd_t;

    typedef struct packed {
        logic pos_zero;   // next byte starts a fresh keystream block
        logic hold_last;  // held word ends its message
    } status_t;

    // Half of a quarter round: two dependent additions per call.
    function automatic qr_t qr_half(input word_t a, input word_t b, input word_t c,
                                    input word_t d, input logic second);
        word_t a2;
        word_t dx;
        word_t d2;
        word_t c2;
        word_t bx;
        word_t b2;
        qr_t   r;
        a2 = a + b;
        dx = d ^ a2;
        d2 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
        c2 = c + d2;
        bx = b ^ c2;
        b2 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
        r.a = a2;
        r.b = b2;
        r.c = c2;
        r.d = d2;
        return r;
    endfunction

endpackage

@@ rtl/core/chacha20_stream_xor_core.sv @@
// ChaCha20 stream transform: each byte is XORed with the next keystream byte.
// Built from chacha_ctrl and chacha_dp; depends on chacha_pkg.
//
// Usage: bytes enter on the s_ stream (s_tdata holds the byte, s_tlast marks the
// final byte of a message) and leave on the m_ stream with the same framing.
// Key, nonce and the starting block counter are written through the cfg_ port
// while the block is idle; register i of the list is written at index i, and
// indexes beyond the list are ignored.
// The first byte of a message, and each 64th byte after it, first builds a
// keystream block: a load, four half-round steps per double round (40 for
// twenty rounds), an add-back step and the write of the result, which waits
// while the output register is blocked. Every other byte is written to the
// output register in the cycle it is accepted, one byte per cycle while the
// receiver does not stall.
// The quarter-round lanes, reused for every half-round step, set the block time.
// Reset clears the configuration and the message state and empties the output register.
// When the receiver stalls, the result waits in the output register and a new
// byte is taken only once that register is free or being emptied.
module chacha20_stream_xor_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [chacha_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [chacha_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // data_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // result_byte
    output logic                            m_tlast
);

    chacha_pkg::cmd_t    cmd;
    chacha_pkg::status_t status;

    chacha_ctrl #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tlast (s_tlast),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    chacha_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

@@ rtl/core/chacha_ctrl.sv @@
// Controller state machine of the ChaCha20 stream core: handshake, round sequencing.
// Depends on chacha_pkg; drives chacha_dp through chacha_pkg::cmd_t.
module chacha_ctrl #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  chacha_pkg::status_t status,
    output chacha_pkg::cmd_t    cmd
);

    localparam int StepCount = DOUBLE_ROUNDS * 4;
    localparam int StepW     = $clog2(StepCount);
    localparam logic [StepW-1:0] StepLast = StepW'(StepCount - 1);

    typedef enum logic [3:0] {
        ST_READY = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FIN   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             in_msg_reg, in_msg_next;
    logic             out_free;

    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        in_msg_next = in_msg_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.diag    = step_reg[1];
        cmd.second  = step_reg[0];
        unique case (state_reg)
            ST_READY: begin
                s_tready = out_free;
                if (s_tvalid && out_free) begin
                    if (!in_msg_reg || status.pos_zero) begin
                        cmd.load    = 1'b1;
                        cmd.new_msg = !in_msg_reg;
                        cmd.capture = 1'b1;
                        in_msg_next = 1'b1;
                        step_next   = '0;
                        state_next  = ST_ROUND;
                    end else begin
                        cmd.emit    = 1'b1;
                        in_msg_next = !s_tlast;
                    end
                end
            end
            ST_ROUND: begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == StepLast) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_hold = 1'b1;
                    if (status.hold_last) begin
                        in_msg_next = 1'b0;
                    end
                    state_next = ST_READY;
                end
            end
            default: begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_READY;
            step_reg   <= '0;
            in_msg_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            in_msg_reg <= in_msg_next;
        end
    end

endmodule

@@ rtl/core/chacha_dp.sv @@
// Datapath of the ChaCha20 stream core: configuration, working state, keystream
// block, byte position, block counter and output register. Depends on chacha_pkg.
module chacha_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [chacha_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [chacha_pkg::CfgDataW-1:0]     cfg_wdata,
    input  logic [7:0]                          s_tdata,
    input  logic                                s_tlast,
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  chacha_pkg::cmd_t                    cmd,
    output chacha_pkg::status_t                 status
);

    chacha_pkg::word_t key_reg [8];
    chacha_pkg::word_t nonce_reg [3];
    chacha_pkg::word_t init_ctr_reg;
    chacha_pkg::word_t ctr_reg;
    chacha_pkg::word_t ctr_sel;
    chacha_pkg::word_t work_reg [16];
    chacha_pkg::word_t work_next [16];
    chacha_pkg::word_t ks_reg [16];
    chacha_pkg::word_t init_words [16];
    chacha_pkg::qr_t   col_res [4];
    chacha_pkg::qr_t   diag_res [4];
    chacha_pkg::word_t ks_word;

    logic [5:0] pos_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_last_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_valid_reg;
    logic [7:0] src_byte;
    logic       src_last;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                key_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                nonce_reg[i] <= '0;
            end
            init_ctr_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                chacha_pkg::CFG_KEY_01: begin
                    key_reg[0] <= cfg_wdata[31:0];
                    key_reg[1] <= cfg_wdata[63:32];
                end
                chacha_pkg::CFG_KEY_23: begin
                    key_reg[2] <= cfg_wdata[31:0];
                    key_reg[3] <= cfg_wdata[63:32];
                end
                chacha_pkg::CFG_KEY_45: begin
                    key_reg[4] <= cfg_wdata[31:0];
                    key_reg[5] <= cfg_wdata[63:32];
                end
                chacha_pkg::CFG_KEY_67: begin
                    key_reg[6] <= cfg_wdata[31:0];
                    key_reg[7] <= cfg_wdata[63:32];
                end
                chacha_pkg::CFG_NONCE_01: begin
                    nonce_reg[0] <= cfg_wdata[31:0];
                    nonce_reg[1] <= cfg_wdata[63:32];
                end
                chacha_pkg::CFG_NONCE_2: begin
                    nonce_reg[2] <= cfg_wdata[31:0];
                end
                chacha_pkg::CFG_INIT_CTR: begin
                    init_ctr_reg <= cfg_wdata[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A message start takes the configured counter; otherwise the running one.
    assign ctr_sel = cmd.new_msg ? init_ctr_reg : ctr_reg;

    always_comb begin
        init_words[0] = chacha_pkg::SIGMA_0;
        init_words[1] = chacha_pkg::SIGMA_1;
        init_words[2] = chacha_pkg::SIGMA_2;
        init_words[3] = chacha_pkg::SIGMA_3;
        for (int i = 0; i < 8; i++) begin
            init_words[4 + i] = key_reg[i];
        end
        init_words[12] = cmd.load ? ctr_sel : ctr_reg;
        init_words[13] = nonce_reg[0];
        init_words[14] = nonce_reg[1];
        init_words[15] = nonce_reg[2];
    end

    // Column and diagonal lanes are both formed; the round type picks one.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            col_res[i] = chacha_pkg::qr_half(work_reg[i], work_reg[4 + i],
                                             work_reg[8 + i], work_reg[12 + i], cmd.second);
            diag_res[i] = chacha_pkg::qr_half(work_reg[i], work_reg[4 + ((i + 1) % 4)],
                                              work_reg[8 + ((i + 2) % 4)],
                                              work_reg[12 + ((i + 3) % 4)], cmd.second);
        end
        for (int i = 0; i < 16; i++) begin
            work_next[i] = work_reg[i];
        end
        for (int i = 0; i < 4; i++) begin
            if (cmd.diag) begin
                work_next[i]                = diag_res[i].a;
                work_next[4 + ((i + 1) % 4)]  = diag_res[i].b;
                work_next[8 + ((i + 2) % 4)]  = diag_res[i].c;
                work_next[12 + ((i + 3) % 4)] = diag_res[i].d;
            end else begin
                work_next[i]      = col_res[i].a;
                work_next[4 + i]  = col_res[i].b;
                work_next[8 + i]  = col_res[i].c;
                work_next[12 + i] = col_res[i].d;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            if (cmd.load) begin
                work_reg[i] <= init_words[i];
            end else if (cmd.step) begin
                work_reg[i] <= work_next[i];
            end
            if (cmd.finish) begin
                ks_reg[i] <= work_reg[i] + init_words[i];
            end
        end
        if (cmd.capture) begin
            hold_byte_reg <= s_tdata;
            hold_last_reg <= s_tlast;
        end
    end

    assign src_byte = cmd.emit_hold ? hold_byte_reg : s_tdata;
    assign src_last = cmd.emit_hold ? hold_last_reg : s_tlast;
    assign ks_word  = ks_reg[pos_reg[5:2]];

    // Byte position, block counter and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                ctr_reg <= ctr_sel;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                if (src_last) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 6'd1;
                end
                if (pos_reg == 6'd63) begin
                    ctr_reg <= ctr_reg + 32'd1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_byte_reg <= src_byte ^ ks_word[{pos_reg[1:0], 3'b000} +: 8];
            out_last_reg <= src_last;
        end
    end

    assign m_tdata          = out_byte_reg;
    assign m_tlast          = out_last_reg;
    assign m_tvalid         = out_valid_reg;
    assign status.pos_zero  = (pos_reg == 6'd0);
    assign status.hold_last = hold_last_reg;

endmodule

@@ rtl/core/chacha_checker.sv @@
// Port-level checks for chacha20_stream_xor_core, attached by the bind below.
// Sees only the top level's ports; depends on nothing else.
module chacha_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A result held back by the receiver stays, unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed or vanished while stalled");

    // A word is only taken when the output register can receive its result.
    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input word taken while output register is blocked");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present straight after reset");

    // Out of reset the handshake is always defined, and so is a result on offer.
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_tready, m_tvalid}) && (!m_tvalid || !$isunknown({m_tdata, m_tlast})))
        else $error("handshake or result word undefined after reset");

endmodule

bind chacha20_stream_xor_core chacha_checker u_chacha_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
